/* hw/rtl/tmg_pkg.sv */
// shared types, constants and tables for the transform matrix generator
package tmg_pkg;

  typedef enum logic [2:0] {
    FN_ROT_X  = 3'd0,
    FN_ROT_Y  = 3'd1,
    FN_ROT_Z  = 3'd2,
    FN_AXIS   = 3'd3,
    FN_XLATE  = 3'd4,
    FN_SCALE  = 3'd5
  } func_t;

  localparam int TABLE_LEN = 24;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  function automatic logic [31:0] atan_turns(input int idx);
    logic [31:0] r;
    case (idx)
      0: r = 32'd536870912;
      1: r = 32'd316933406;
      2: r = 32'd167458907;
      3: r = 32'd85004756;
      4: r = 32'd42667331;
      5: r = 32'd21354465;
      6: r = 32'd10680862;
      7: r = 32'd5340245;
      8: r = 32'd2670163;
      9: r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41721;
      15: r = 32'd20860;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2607;
      19: r = 32'd1303;
      20: r = 32'd651;
      21: r = 32'd325;
      22: r = 32'd162;
      23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // request state carried alongside the angle pipeline
  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] sf;
  } req_t;

endpackage

/* hw/rtl/tmg_cordic.sv */
// pipelined rotation-mode cordic producing q16 sine and cosine
module tmg_cordic #(
  parameter int CORDIC_STAGES = 16,
  parameter int ANGLE_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [15:0]         angle,
  input  tmg_pkg::req_t       in_req,
  output logic                out_valid,
  output tmg_pkg::req_t       out_req,
  output logic signed [17:0]  cos_q16,
  output logic signed [17:0]  sin_q16
);
  localparam int N = (CORDIC_STAGES < tmg_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                         : tmg_pkg::TABLE_LEN;
  localparam int AW = ANGLE_BITS + 2;
  localparam int TSH = 32 - ANGLE_BITS;
  localparam logic signed [AW-1:0] FULL = AW'(1) <<< ANGLE_BITS;
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (ANGLE_BITS - 1);
  localparam logic signed [AW-1:0] QUART = AW'(1) <<< (ANGLE_BITS - 2);

  // angle fold stage
  logic [ANGLE_BITS-1:0] a_scaled;
  logic signed [AW-1:0]  z0, z_f;
  logic                  flip_f;
  generate
    if (ANGLE_BITS >= 16) begin : g_up
      assign a_scaled = ANGLE_BITS'({angle, {(ANGLE_BITS-16+1){1'b0}}} >> 1);
    end else begin : g_dn
      assign a_scaled = angle[15 -: ANGLE_BITS];
    end
  endgenerate

  always_comb begin
    z0 = AW'({1'b0, a_scaled});
    if (z0 >= HALF) z0 = z0 - FULL;
    flip_f = 1'b0;
    z_f = z0;
    if (z0 > QUART) begin
      z_f = z0 - HALF;
      flip_f = 1'b1;
    end else if (z0 < -QUART) begin
      z_f = z0 + HALF;
      flip_f = 1'b1;
    end
  end

  logic signed [33:0]   x [0:N];
  logic signed [33:0]   y [0:N];
  logic signed [AW-1:0] z [0:N];
  logic                 fl [0:N];
  logic                 v  [0:N];
  tmg_pkg::req_t        rq [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid;
    end
    if (adv) begin
      x[0] <= tmg_pkg::CORDIC_GAIN_Q30;
      y[0] <= '0;
      z[0] <= z_f;
      fl[0] <= flip_f;
      rq[0] <= in_req;
    end
  end

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_st
      localparam logic signed [AW-1:0] DA =
        AW'(tmg_pkg::atan_turns(i) >> TSH);
      always_ff @(posedge clk) begin
        if (rst) begin
          v[i+1] <= 1'b0;
        end else if (adv) begin
          v[i+1] <= v[i];
        end
        if (adv) begin
          if (z[i] >= 0) begin
            x[i+1] <= x[i] - (y[i] >>> i);
            y[i+1] <= y[i] + (x[i] >>> i);
            z[i+1] <= z[i] - DA;
          end else begin
            x[i+1] <= x[i] + (y[i] >>> i);
            y[i+1] <= y[i] - (x[i] >>> i);
            z[i+1] <= z[i] + DA;
          end
          fl[i+1] <= fl[i];
          rq[i+1] <= rq[i];
        end
      end
    end
  endgenerate

  // round, flip and clamp
  logic signed [33:0] xr, yr;
  logic signed [19:0] xc, yc;
  always_comb begin
    xr = (x[N] + 34'sd8192) >>> 14;
    yr = (y[N] + 34'sd8192) >>> 14;
    xc = fl[N] ? -xr[19:0] : xr[19:0];
    yc = fl[N] ? -yr[19:0] : yr[19:0];
    if (xc > 20'sd65536) xc = 20'sd65536;
    if (xc < -20'sd65536) xc = -20'sd65536;
    if (yc > 20'sd65536) yc = 20'sd65536;
    if (yc < -20'sd65536) yc = -20'sd65536;
  end

  assign out_valid = v[N];
  assign out_req   = rq[N];
  assign cos_q16   = xc[17:0];
  assign sin_q16   = yc[17:0];
endmodule

/* hw/rtl/transform_matrix_generator.sv */
// top level: 4x4 homogeneous transform matrix generator
// A request enters a pipeline of CORDIC_STAGES+1 cordic stages (CORDIC_STAGES
// capped at TABLE_LEN) followed by five arithmetic stages (magnitudes, 32x32
// products, t scaling, signed triple products, entry sums) and lands in a
// one-deep matrix buffer. The matrix then leaves as sixteen entries, one per
// cycle while out_stall is low, so throughput is set by the single result port.
// While the buffer is full and its entries are being sent, the next request
// already moves through the pipeline behind it.
module transform_matrix_generator #(
  parameter int CORDIC_STAGES = 16,
  parameter int ANGLE_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         func,
  input  logic signed [15:0] turn_angle,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  input  logic signed [31:0] scale_factor,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         row_index,
  output logic [1:0]         col_index,
  output logic signed [31:0] entry_value,
  output logic               last_entry
);
  logic adv;
  logic buf_full, buf_load, buf_done;

  tmg_pkg::req_t req_in;
  assign req_in = '{func: func, vx: vec_x, vy: vec_y, vz: vec_z, sf: scale_factor};

  logic               c_valid;
  tmg_pkg::req_t      c_req;
  logic signed [17:0] c_cos, c_sin;

  tmg_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(in_valid),
    .angle(turn_angle), .in_req(req_in),
    .out_valid(c_valid), .out_req(c_req), .cos_q16(c_cos), .sin_q16(c_sin)
  );

  // stage a: magnitudes and signs of the vector components, cos/sin held
  logic               a_v;
  tmg_pkg::req_t      a_req;
  logic signed [17:0] a_c, a_s;
  logic [31:0]        a_m [0:2];
  logic               a_n [0:2];

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [32:0] e;
    e = v[31] ? -{v[31], v} : {v[31], v};
    return e[31:0];
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [53:0] v);
    if (v > 54'sd2147483647) return 32'sh7fffffff;
    if (v < -54'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // stage b: exact magnitude products and s*v products
  logic               b_v;
  tmg_pkg::req_t      b_req;
  logic signed [17:0] b_c, b_s;
  logic [63:0]        b_p [0:5];   // xx yy zz xy xz yz
  logic [5:0]         b_pn;
  logic signed [49:0] b_sv [0:2];  // s*x s*y s*z

  // stage c: t*lo and t*hi partials, rounded s*v
  logic               c2_v;
  tmg_pkg::req_t      c2_req;
  logic signed [17:0] c2_c, c2_s;
  logic [49:0]        c2_hi [0:5];
  logic [49:0]        c2_lo [0:5];
  logic [5:0]         c2_pn;
  logic signed [33:0] c2_sv [0:2];

  // stage d: triple products signed
  logic               d_v;
  tmg_pkg::req_t      d_req;
  logic signed [17:0] d_c, d_s;
  logic signed [51:0] d_tr [0:5];
  logic signed [33:0] d_sv [0:2];

  // stage e: matrix entries saturated
  logic               e_v;
  logic signed [31:0] e_m [0:15];
  logic signed [53:0] mv [0:15];

  // t reaches 2.0 at a half turn, so it needs 19 signed bits
  logic signed [18:0] t_w;
  assign t_w = 19'sd65536 - 19'(b_c);

  always_comb begin
    for (int k = 0; k < 16; k++) mv[k] = '0;
    mv[0] = 54'sd65536;
    mv[5] = 54'sd65536;
    mv[10] = 54'sd65536;
    mv[15] = 54'sd65536;
    case (d_req.func)
      tmg_pkg::FN_ROT_X: begin
        mv[5] = 54'(d_c); mv[6] = 54'(d_s); mv[9] = -54'(d_s); mv[10] = 54'(d_c);
      end
      tmg_pkg::FN_ROT_Y: begin
        mv[0] = 54'(d_c); mv[2] = -54'(d_s); mv[8] = 54'(d_s); mv[10] = 54'(d_c);
      end
      tmg_pkg::FN_ROT_Z: begin
        mv[0] = 54'(d_c); mv[1] = 54'(d_s); mv[4] = -54'(d_s); mv[5] = 54'(d_c);
      end
      tmg_pkg::FN_AXIS: begin
        mv[0] = 54'(d_c) + 54'(d_tr[0]);
        mv[1] = 54'(d_tr[3]) + 54'(d_sv[2]);
        mv[2] = 54'(d_tr[4]) - 54'(d_sv[1]);
        mv[4] = 54'(d_tr[3]) - 54'(d_sv[2]);
        mv[5] = 54'(d_c) + 54'(d_tr[1]);
        mv[6] = 54'(d_tr[5]) + 54'(d_sv[0]);
        mv[8] = 54'(d_tr[4]) + 54'(d_sv[1]);
        mv[9] = 54'(d_tr[5]) - 54'(d_sv[0]);
        mv[10] = 54'(d_c) + 54'(d_tr[2]);
      end
      tmg_pkg::FN_XLATE: begin
        mv[3] = 54'(d_req.vx); mv[7] = 54'(d_req.vy); mv[11] = 54'(d_req.vz);
      end
      tmg_pkg::FN_SCALE: begin
        mv[0] = 54'(d_req.sf); mv[5] = 54'(d_req.sf); mv[10] = 54'(d_req.sf);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0; b_v <= 1'b0; c2_v <= 1'b0; d_v <= 1'b0; e_v <= 1'b0;
    end else if (adv) begin
      a_v <= c_valid; b_v <= a_v; c2_v <= b_v; d_v <= c2_v; e_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_req <= c_req; a_c <= c_cos; a_s <= c_sin;
      a_m[0] <= mag32(c_req.vx); a_m[1] <= mag32(c_req.vy); a_m[2] <= mag32(c_req.vz);
      a_n[0] <= c_req.vx[31]; a_n[1] <= c_req.vy[31]; a_n[2] <= c_req.vz[31];

      b_req <= a_req; b_c <= a_c; b_s <= a_s;
      b_p[0] <= 64'(a_m[0]) * 64'(a_m[0]);
      b_p[1] <= 64'(a_m[1]) * 64'(a_m[1]);
      b_p[2] <= 64'(a_m[2]) * 64'(a_m[2]);
      b_p[3] <= 64'(a_m[0]) * 64'(a_m[1]);
      b_p[4] <= 64'(a_m[0]) * 64'(a_m[2]);
      b_p[5] <= 64'(a_m[1]) * 64'(a_m[2]);
      b_pn <= {a_n[1] ^ a_n[2], a_n[0] ^ a_n[2], a_n[0] ^ a_n[1], 3'b000};
      b_sv[0] <= 50'(a_s) * 50'(a_req.vx);
      b_sv[1] <= 50'(a_s) * 50'(a_req.vy);
      b_sv[2] <= 50'(a_s) * 50'(a_req.vz);

      c2_req <= b_req; c2_c <= b_c; c2_s <= b_s; c2_pn <= b_pn;
      for (int k = 0; k < 6; k++) begin
        c2_hi[k] <= 50'(t_w[17:0]) * 50'(b_p[k][63:32]);
        c2_lo[k] <= 50'(t_w[17:0]) * 50'(b_p[k][31:0]);
      end
      for (int k = 0; k < 3; k++) begin
        c2_sv[k] <= 34'((b_sv[k] + 50'sd32768) >>> 16);
      end

      d_req <= c2_req; d_c <= c2_c; d_s <= c2_s;
      for (int k = 0; k < 6; k++) begin
        logic [51:0] r;
        r = 52'(c2_hi[k]) + 52'((c2_lo[k] + 50'h80000000) >> 32);
        d_tr[k] <= c2_pn[k] ? -$signed(r) : $signed(r);
      end
      for (int k = 0; k < 3; k++) d_sv[k] <= c2_sv[k];

      for (int k = 0; k < 16; k++) e_m[k] <= sat(mv[k]);
    end
  end

  assign buf_load = e_v && (!buf_full || buf_done);
  assign adv = !e_v || buf_load;
  assign in_stall = !adv;

  logic [3:0]         idx;
  logic signed [31:0] mat [0:15];
  assign buf_done = buf_full && !out_stall && (idx == 4'd15);

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_full <= 1'b0;
      idx <= '0;
    end else begin
      if (buf_full && !out_stall) idx <= idx + 4'd1;
      if (buf_load) buf_full <= 1'b1;
      else if (buf_done) buf_full <= 1'b0;
    end
    if (buf_load) mat <= e_m;
  end

  assign out_valid   = buf_full;
  assign row_index   = idx[3:2];
  assign col_index   = idx[1:0];
  assign entry_value = mat[idx];
  assign last_entry  = (idx == 4'd15);
endmodule
